// File: src/m3inv_pkg.sv
package m3inv_pkg;

	localparam int EW = 32;

	typedef struct packed {
		logic signed [EW-1:0] a00;
		logic signed [EW-1:0] a01;
		logic signed [EW-1:0] a02;
		logic signed [EW-1:0] a10;
		logic signed [EW-1:0] a11;
		logic signed [EW-1:0] a12;
		logic signed [EW-1:0] a20;
		logic signed [EW-1:0] a21;
		logic signed [EW-1:0] a22;
	} m3inv_in_t;

	typedef struct packed {
		logic signed [EW-1:0] r00;
		logic signed [EW-1:0] r01;
		logic signed [EW-1:0] r02;
		logic signed [EW-1:0] r10;
		logic signed [EW-1:0] r11;
		logic signed [EW-1:0] r12;
		logic signed [EW-1:0] r20;
		logic signed [EW-1:0] r21;
		logic signed [EW-1:0] r22;
		logic                 singular;
	} m3inv_out_t;

endpackage

// File: src/matrix3_inverse_top.sv
// channel | ports                      | handshake
// in      | start, busy, in_item       | taken when start && !busy
// out     | done, out_item             | one-cycle strobe, cannot stall
//
// One item enters per cycle; busy is tied low. The pipeline registers are:
// cofactors, determinant partial products (no product wider than
// 32 x 33), determinant sum and cofactor magnitudes, determinant
// magnitude and signs, restoring division stages (one quotient bit per
// stage, all nine elements in parallel), then a saturation/output
// register. The receiver cannot stall, so nothing waits.
// Reset clears only the valid bits; payload registers are not reset.
module matrix3_inverse_top import m3inv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  m3inv_in_t  in_item,
	output logic       done,
	output m3inv_out_t out_item
);
	localparam int W   = EW;
	localparam int F   = 16;
	localparam int CW  = 2*W + 1;           // cofactor width
	localparam int DW  = 3*W + 2;           // determinant width
	localparam int NW  = CW + 2*F;          // shifted numerator magnitude
	localparam int QW  = W + 1;             // quotient bits kept (+ overflow)
	localparam int HI  = NW - QW;           // bits above the kept quotient
	localparam int RW  = DW + 1;

	typedef logic signed [W-1:0]  el_t;
	typedef logic signed [CW-1:0] cf_t;
	typedef logic [NW-1:0]        nm_t;
	typedef logic [RW-1:0]        rm_t;

	assign busy = 1'b0;

	logic v_s1;
	el_t  m_s1 [9];
	cf_t  c_s1 [9];

	// stage 1: cofactors
	el_t m_in [9];
	always_comb begin
		m_in[0] = in_item.a00; m_in[1] = in_item.a01; m_in[2] = in_item.a02;
		m_in[3] = in_item.a10; m_in[4] = in_item.a11; m_in[5] = in_item.a12;
		m_in[6] = in_item.a20; m_in[7] = in_item.a21; m_in[8] = in_item.a22;
	end

	function automatic cf_t cof(el_t p, el_t q, el_t s, el_t t);
		cf_t a;
		cf_t b;
		a = CW'($signed(p) * $signed(q));
		b = CW'($signed(s) * $signed(t));
		return a - b;
	endfunction

	always_ff @(posedge clk) begin
		m_s1 <= m_in;
		c_s1[0] <= cof(m_in[4], m_in[8], m_in[5], m_in[7]);
		c_s1[1] <= cof(m_in[2], m_in[7], m_in[1], m_in[8]);
		c_s1[2] <= cof(m_in[1], m_in[5], m_in[2], m_in[4]);
		c_s1[3] <= cof(m_in[5], m_in[6], m_in[3], m_in[8]);
		c_s1[4] <= cof(m_in[0], m_in[8], m_in[2], m_in[6]);
		c_s1[5] <= cof(m_in[2], m_in[3], m_in[0], m_in[5]);
		c_s1[6] <= cof(m_in[3], m_in[7], m_in[4], m_in[6]);
		c_s1[7] <= cof(m_in[1], m_in[6], m_in[0], m_in[7]);
		c_s1[8] <= cof(m_in[0], m_in[4], m_in[1], m_in[3]);
	end

	// stage 2: determinant partial products; each of the cofactors c_s1[0],
	// c_s1[3] and c_s1[6] is split into a signed high part and an unsigned low part
	cf_t  pl_s2 [3];
	cf_t  ph_s2 [3];
	el_t  m_s2 [9];
	cf_t  c_s2 [9];
	logic v_s2;
	always_ff @(posedge clk) begin
		m_s2 <= m_s1;
		c_s2 <= c_s1;
		for (int j = 0; j < 3; j++) begin
			pl_s2[j] <= $signed(m_s1[j]) * $signed({1'b0, c_s1[3*j][W-1:0]});
			ph_s2[j] <= $signed(m_s1[j]) * $signed(c_s1[3*j][CW-1:W]);
		end
	end

	// stage 3: determinant sum, cofactor magnitudes
	logic signed [DW-1:0] dsum;
	always_comb begin
		dsum = '0;
		for (int j = 0; j < 3; j++)
			dsum = dsum + (DW'(ph_s2[j]) <<< W) + DW'(pl_s2[j]);
	end

	logic signed [DW-1:0] det_s3;
	el_t  m_s3 [9];
	nm_t  n_s3 [9];
	logic [8:0] cs_s3;
	logic v_s3;
	always_ff @(posedge clk) begin
		m_s3 <= m_s2;
		det_s3 <= dsum;
		for (int i = 0; i < 9; i++) begin
			cs_s3[i] <= c_s2[i][CW-1];
			n_s3[i]  <= NW'(c_s2[i][CW-1] ? -c_s2[i] : c_s2[i]) << (2*F);
		end
	end

	// stage 4: determinant magnitude, zero test, result signs
	el_t  m_s4 [9];
	nm_t  n_s4 [9];
	rm_t  d_s4;
	logic [8:0] ng_s4;
	logic z_s4, v_s4;
	always_ff @(posedge clk) begin
		m_s4 <= m_s3;
		n_s4 <= n_s3;
		z_s4 <= (det_s3 == '0);
		d_s4 <= det_s3[DW-1] ? RW'(-det_s3) : RW'(det_s3);
		ng_s4 <= cs_s3 ^ {9{det_s3[DW-1]}};
	end

	// Quotient bits above QW would force saturation: |num| >= d << QW.
	// Detected exactly by comparing the high part of num against d.
	// Division pipeline: stage k handles quotient bit QW-1-k.
	rm_t  r_p  [QW+1][9];
	logic [QW-1:0] q_p [QW+1][9];
	logic [8:0] big_p [QW+1];
	logic [8:0] ng_p [QW+1];
	nm_t  n_p  [QW+1][9];
	rm_t  d_p  [QW+1];
	el_t  m_p  [QW+1][9];
	logic z_p  [QW+1];
	logic v_p  [QW+1];

	always_comb begin
		d_p[0] = d_s4; z_p[0] = z_s4; v_p[0] = v_s4; ng_p[0] = ng_s4;
		m_p[0] = m_s4; n_p[0] = n_s4;
		for (int i = 0; i < 9; i++) begin
			r_p[0][i]  = RW'(n_s4[i] >> QW);
			big_p[0][i] = (RW'(n_s4[i] >> QW) >= d_s4);
			q_p[0][i]  = '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		always_ff @(posedge clk) begin
			d_p[k+1] <= d_p[k]; z_p[k+1] <= z_p[k]; ng_p[k+1] <= ng_p[k];
			m_p[k+1] <= m_p[k]; n_p[k+1] <= n_p[k]; big_p[k+1] <= big_p[k];
			for (int i = 0; i < 9; i++) begin
				logic [RW:0] t;
				t = {r_p[k][i], n_p[k][i][QW-1-k]};
				if (t >= {1'b0, d_p[k]}) begin
					r_p[k+1][i] <= RW'(t - {1'b0, d_p[k]});
					q_p[k+1][i] <= q_p[k][i] | (QW'(1) << (QW-1-k));
				end else begin
					r_p[k+1][i] <= RW'(t);
					q_p[k+1][i] <= q_p[k][i];
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_p[k+1] <= 1'b0;
			else         v_p[k+1] <= v_p[k];
		end
	end

	// output: saturate and pass through on zero determinant
	el_t res [9];
	localparam logic [QW-1:0] LIM = QW'(1) << (W-1);
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			logic [QW-1:0] q;
			q = q_p[QW][i];
			if (z_p[QW])
				res[i] = m_p[QW][i];
			else if (ng_p[QW][i])
				res[i] = (big_p[QW][i] || q > LIM) ? el_t'(LIM) : el_t'(-q);
			else
				res[i] = (big_p[QW][i] || q > LIM - 1) ? el_t'(LIM - 1) : el_t'(q);
		end
	end

	always_ff @(posedge clk) begin
		out_item.r00 <= res[0]; out_item.r01 <= res[1]; out_item.r02 <= res[2];
		out_item.r10 <= res[3]; out_item.r11 <= res[4]; out_item.r12 <= res[5];
		out_item.r20 <= res[6]; out_item.r21 <= res[7]; out_item.r22 <= res[8];
		out_item.singular <= z_p[QW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; done <= 1'b0;
		end else begin
			v_s1 <= start; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			done <= v_p[QW];
		end
	end
endmodule
